// ----- hw/rtl/mtt_pkg.sv -----
// Shared types, codes and constants of the multi-timer table.
package mtt_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int MAX_RESULTS   = 64;
  localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] TPM_RESET = 32'd2400000;

  localparam logic [2:0] ADDR_TPM = 3'd0;

  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [2:0] STS_CREATED   = 3'd0;
  localparam logic [2:0] STS_NO_SLOT   = 3'd1;
  localparam logic [2:0] STS_CANCELLED = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STS_EXPIRED   = 3'd4;
  localparam logic [2:0] STS_TIME      = 3'd5;

  // Command as classified by the front end, delays already scaled to ticks.
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] owner;
    logic [31:0] cancel_id;
    logic [63:0] delay_ticks;
    logic [63:0] period_ticks;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [31:0] owner;
    logic        wake;
    logic [63:0] time_value;
  } res_t;

endpackage

// ----- hw/rtl/multi_timer_table.sv -----
// Multi-timer table top level: configuration register, front end, queue and scan engine.
//
// A table of NUM_SLOTS one-shot or periodic timers kept against a 64-bit time
// counter. Create, cancel and tick items pass through the engine in order: it
// takes the command from the queue, walks the slot table (one memory with one
// read and one write port, one slot per cycle while the scan is not held, plus
// the drain of its registered read) and hands over the final result. A
// read-time item skips the walk. A tick holds its scan whenever a second
// expiry is found while the result register is full and stalled, and every
// item with a final result waits at its end until the result register can take
// it; a tick that found no expiry has none. After reset the engine clears the
// slot table, one slot per cycle, and accepts no item during that pass.
// A two-entry queue lets the input side take items while the engine scans.
// ticks_per_ms sits at byte address 0 and should be written only while idle.
module multi_timer_table #(
  parameter int NUM_SLOTS = mtt_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_wait_msec,
  input  logic [31:0] in_reload_msec,
  input  logic [31:0] in_owner_id,
  input  logic [31:0] in_cancel_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_id,
  output logic [31:0] out_result_owner,
  output logic        out_wake,
  output logic [63:0] out_time_value,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]   tpm_r;
  logic          tpm_wr;
  logic          q_push;
  mtt_pkg::cmd_t q_in_cmd;
  mtt_pkg::cmd_t q_head_cmd;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic          clearing;
  mtt_pkg::res_t res;

  assign pready = 1'b1;
  assign tpm_wr = psel && penable && pwrite && (paddr == mtt_pkg::ADDR_TPM);
  assign prdata = (paddr == mtt_pkg::ADDR_TPM) ? tpm_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r <= mtt_pkg::TPM_RESET;
    end else if (tpm_wr) begin
      tpm_r <= pwdata;
    end
  end

  mtt_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_wait_msec   (in_wait_msec),
    .in_reload_msec (in_reload_msec),
    .in_owner_id    (in_owner_id),
    .in_cancel_id   (in_cancel_id),
    .ticks_per_ms   (tpm_r),
    .q_full         (q_full),
    .clearing       (clearing),
    .q_push         (q_push),
    .q_cmd          (q_in_cmd)
  );

  mtt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  mtt_engine #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (q_head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_status       = res.status;
  assign out_result_id    = res.id;
  assign out_result_owner = res.owner;
  assign out_wake         = res.wake;
  assign out_time_value   = res.time_value;

endmodule

// ----- hw/rtl/mtt_front.sv -----
// Front end: accepts items, scales delays to ticks and classifies them into commands.
module mtt_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [31:0]       in_wait_msec,
  input  logic [31:0]       in_reload_msec,
  input  logic [31:0]       in_owner_id,
  input  logic [31:0]       in_cancel_id,
  input  logic [31:0]       ticks_per_ms,
  input  logic              q_full,
  input  logic              clearing,
  output logic              q_push,
  output mtt_pkg::cmd_t     q_cmd
);

  logic [63:0] delay_prod;
  logic [63:0] period_prod;

  assign delay_prod  = {32'd0, in_wait_msec} * {32'd0, ticks_per_ms};
  assign period_prod = {32'd0, in_reload_msec} * {32'd0, ticks_per_ms};

  // hold off while the queue is full or the slot table is being cleared
  assign in_stall = q_full || clearing;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_cmd.func         = in_func;
    q_cmd.owner        = 32'd0;
    q_cmd.cancel_id    = 32'd0;
    q_cmd.delay_ticks  = 64'd0;
    q_cmd.period_ticks = 64'd0;
    case (in_func)
      mtt_pkg::FUNC_CREATE: begin
        q_cmd.owner        = in_owner_id;
        q_cmd.delay_ticks  = delay_prod;
        q_cmd.period_ticks = period_prod;
      end
      mtt_pkg::FUNC_CANCEL: begin
        q_cmd.cancel_id = in_cancel_id;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/mtt_queue.sv -----
// Short command queue between the front end and the scan engine.
module mtt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mtt_pkg::cmd_t push_cmd,
  input  logic          pop,
  output mtt_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);

  localparam int Depth = mtt_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (mtt_pkg::QUEUE_PTR_W > 0) ? mtt_pkg::QUEUE_PTR_W : 1;
  localparam int CntW  = mtt_pkg::QUEUE_CNT_W;

  mtt_pkg::cmd_t     q_mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == CntW'(Depth));
  assign empty    = (cnt_r == '0);
  assign head_cmd = q_mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hw/rtl/mtt_engine.sv -----
// Scan engine: slot table memory, time counter, per-slot scan and result register.
module mtt_engine #(
  parameter int NUM_SLOTS = mtt_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mtt_pkg::cmd_t q_cmd,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          clearing,
  output logic          out_valid,
  input  logic          out_stall,
  output mtt_pkg::res_t out_res,
  output logic          out_last
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW = $clog2(NUM_SLOTS + 1);
  localparam int ResW = mtt_pkg::RES_CNT_W;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  typedef struct packed {
    logic        active;
    logic [31:0] ident;
    logic [31:0] owner;
    logic [63:0] expiry;
    logic [63:0] period;
  } slot_t;

  slot_t             slot_mem [NUM_SLOTS];
  slot_t             rd_q;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  slot_t             wr_data;

  logic [1:0]        state_r, state_nxt;
  mtt_pkg::cmd_t     cmd_r;
  logic [63:0]       time_r;
  logic [31:0]       id_r;
  logic [IdxW-1:0]   clr_idx_r;
  logic [CntW-1:0]   a_idx_r;
  logic              vb_r;
  logic [IdxW-1:0]   b_idx_r;
  logic              found_r;
  logic [ResW-1:0]   cnt_r;
  logic              p_valid_r;
  mtt_pkg::res_t     p_r;
  logic              out_valid_r;
  mtt_pkg::res_t     out_r;
  logic              out_last_r;

  logic              oready;
  logic              a_more;
  logic              due;
  logic              hit;
  logic              b_hit;
  logic              b_block;
  logic              adv;
  logic [63:0]       add_b;
  logic [63:0]       sum;
  mtt_pkg::res_t     hit_res;
  mtt_pkg::res_t     fin_res;
  logic              fin_valid;
  logic              out_push;
  mtt_pkg::res_t     push_res;
  logic              push_last;

  assign oready   = !out_valid_r || !out_stall;
  assign a_more   = (a_idx_r < CntW'(NUM_SLOTS));
  assign clearing = (state_r == S_CLR);
  assign due      = rd_q.active && (time_r >= rd_q.expiry);
  assign add_b    = (cmd_r.func == mtt_pkg::FUNC_CREATE) ? cmd_r.delay_ticks : rd_q.period;
  assign sum      = time_r + add_b;

  always_comb begin
    hit     = 1'b0;
    hit_res = '0;
    case (cmd_r.func)
      mtt_pkg::FUNC_CREATE: begin
        hit            = !rd_q.active && !found_r;
        hit_res.status = mtt_pkg::STS_CREATED;
        hit_res.id     = id_r;
      end
      mtt_pkg::FUNC_CANCEL: begin
        hit            = rd_q.active && (rd_q.ident == cmd_r.cancel_id) && !found_r;
        hit_res.status = mtt_pkg::STS_CANCELLED;
        hit_res.id     = cmd_r.cancel_id;
      end
      mtt_pkg::FUNC_TICK: begin
        hit                = due && (cnt_r < ResW'(mtt_pkg::MAX_RESULTS));
        hit_res.status     = mtt_pkg::STS_EXPIRED;
        hit_res.id         = rd_q.ident;
        hit_res.owner      = rd_q.owner;
        hit_res.wake       = (rd_q.owner != 32'd0);
        hit_res.time_value = time_r;
      end
      default: begin
      end
    endcase
  end

  assign b_hit = (state_r == S_SCAN) && vb_r && hit;
  // a second expiry must push the held one out first; hold the scan if it cannot
  assign b_block = b_hit && p_valid_r && !oready;
  assign adv     = !b_block;

  assign rd_en   = (state_r == S_SCAN) && adv && a_more;
  assign rd_addr = a_idx_r[IdxW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = b_idx_r;
    wr_data = rd_q;
    if (state_r == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = '0;
    end else if (b_hit && adv) begin
      wr_en = 1'b1;
      case (cmd_r.func)
        mtt_pkg::FUNC_CREATE: begin
          wr_data.active = 1'b1;
          wr_data.ident  = id_r;
          wr_data.owner  = cmd_r.owner;
          wr_data.expiry = sum;
          wr_data.period = cmd_r.period_ticks;
        end
        mtt_pkg::FUNC_CANCEL: begin
          wr_data.active = 1'b0;
        end
        default: begin
          // reload a periodic timer, free a one-shot
          if (rd_q.period != 64'd0) begin
            wr_data.expiry = sum;
          end else begin
            wr_data.active = 1'b0;
          end
        end
      endcase
    end
  end

  always_comb begin
    fin_res   = '0;
    fin_valid = 1'b1;
    if (p_valid_r) begin
      fin_res = p_r;
    end else begin
      case (cmd_r.func)
        mtt_pkg::FUNC_CREATE: begin
          fin_res.status = mtt_pkg::STS_NO_SLOT;
        end
        mtt_pkg::FUNC_CANCEL: begin
          fin_res.status = mtt_pkg::STS_NOT_FOUND;
          fin_res.id     = cmd_r.cancel_id;
        end
        mtt_pkg::FUNC_READ: begin
          fin_res.status     = mtt_pkg::STS_TIME;
          fin_res.time_value = time_r;
        end
        default: begin
          fin_valid = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_push  = 1'b0;
    push_res  = p_r;
    push_last = 1'b0;
    if (state_r == S_SCAN) begin
      out_push = b_hit && adv && p_valid_r;
    end else if (state_r == S_FIN) begin
      out_push  = fin_valid && oready;
      push_res  = fin_res;
      push_last = 1'b1;
    end
  end

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_idx_r == IdxW'(NUM_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_cmd.func == mtt_pkg::FUNC_READ) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!a_more && !vb_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!fin_valid || oready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      time_r      <= 64'd0;
      id_r        <= 32'd1;
      clr_idx_r   <= '0;
      a_idx_r     <= '0;
      vb_r        <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (q_pop) begin
        a_idx_r   <= '0;
        vb_r      <= 1'b0;
        found_r   <= 1'b0;
        cnt_r     <= '0;
        p_valid_r <= 1'b0;
        if (q_cmd.func == mtt_pkg::FUNC_TICK) begin
          time_r <= time_r + 64'd1;
        end
      end
      if ((state_r == S_SCAN) && adv) begin
        vb_r <= a_more;
        if (a_more) begin
          a_idx_r <= a_idx_r + 1'b1;
        end
        if (b_hit) begin
          found_r   <= 1'b1;
          cnt_r     <= cnt_r + 1'b1;
          p_valid_r <= 1'b1;
          if (cmd_r.func == mtt_pkg::FUNC_CREATE) begin
            id_r <= id_r + 32'd1;
          end
        end
      end
      if ((state_r == S_FIN) && (state_nxt == S_IDLE)) begin
        p_valid_r <= 1'b0;
      end
      if (out_push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if ((state_r == S_SCAN) && adv) begin
      b_idx_r <= a_idx_r[IdxW-1:0];
      if (b_hit) begin
        p_r <= hit_res;
      end
    end
    if (out_push) begin
      out_r      <= push_res;
      out_last_r <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= slot_mem[rd_addr];
    end
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

endmodule
